### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions that are disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CFCX_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CFCX_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/cfcx_pkg.sv
// ----------------------------------------------------------------------------
// cfcx_pkg
// Shared sizes, codes and types of the credit flow control crossbar.
// ----------------------------------------------------------------------------
`default_nettype none

package cfcx_pkg;

	localparam int PORT_COUNT  = 8;
	localparam int NUM_VC      = 4;
	localparam int QUEUE_DEPTH = 16;

	localparam int NUM_CH    = PORT_COUNT * NUM_VC;
	localparam int CH_W      = $clog2(NUM_CH);
	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int MEM_DEPTH = NUM_CH * QUEUE_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	localparam int PORT_W  = 3;
	localparam int VC_W    = 2;
	localparam int AMT_W   = 16;
	localparam int TAG_W   = 16;
	localparam int CRED_W  = 20;
	localparam int ENTRY_W = AMT_W + TAG_W;
	localparam int CFG_W   = 20;
	localparam int IDX_W   = 1;

	localparam logic [CRED_W-1:0] CREDIT_MAX       = '1;
	localparam logic [CRED_W-1:0] BASE_CREDITS_RST = 20'd1024;

	typedef enum logic {
		OP_PAYLOAD = 1'b0,
		OP_CREDIT  = 1'b1
	} opcode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_BASE_CREDITS = 1'b0,
		REG_USE_NEXT_VC  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_QUEUED  = 2'd1,
		ST_DROPPED = 2'd2
	} status_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [PORT_W-1:0]  port;
		logic [VC_W-1:0]    cur_vc;
		logic [VC_W-1:0]    next_vc;
		logic [AMT_W-1:0]   amount;
		logic [TAG_W-1:0]   tag;
	} item_t;

	typedef struct packed {
		logic               sent;
		logic [PORT_W-1:0]  port;
		logic [VC_W-1:0]    vc;
		logic [AMT_W-1:0]   bytes;
		logic [TAG_W-1:0]   tag;
		status_t            status;
	} result_t;

	typedef struct packed {
		logic               re;
		logic [ADDR_W-1:0]  addr;
	} mem_rd_t;

	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  addr;
		logic [ENTRY_W-1:0] data;
	} mem_wr_t;

	function automatic logic [CRED_W-1:0] per_vc_credits(input logic [CRED_W-1:0] total);
		return total / CRED_W'(NUM_VC);
	endfunction

endpackage

`default_nettype wire

### rtl/cfcx_wait_mem.sv
// ----------------------------------------------------------------------------
// cfcx_wait_mem
// Storage for waiting payloads, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cfcx_wait_mem (
	input  wire logic                          clk,
	input  wire cfcx_pkg::mem_rd_t             rd,
	input  wire cfcx_pkg::mem_wr_t             wr,
	output logic [cfcx_pkg::ENTRY_W-1:0]       rdata
);

	logic [cfcx_pkg::ENTRY_W-1:0] mem [cfcx_pkg::MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// A read of the entry being written returns the new data.
	always_ff @(posedge clk) begin
		if (rd.re) begin
			if (wr.we && (wr.addr == rd.addr)) begin
				rdata <= wr.data;
			end else begin
				rdata <= mem[rd.addr];
			end
		end
	end

endmodule

`default_nettype wire

### rtl/cfcx_chan_ctrl.sv
// ----------------------------------------------------------------------------
// cfcx_chan_ctrl
// Per-channel credit counts and queue pointers, and the forwarding decision.
// ----------------------------------------------------------------------------
`default_nettype none

module cfcx_chan_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [cfcx_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [cfcx_pkg::CFG_W-1:0]    cfg_data,
	input  wire cfcx_pkg::item_t               in_item,
	input  wire logic                          in_accept,
	input  wire cfcx_pkg::item_t               item_s1,
	input  wire logic                          s1_fire,
	input  wire logic [cfcx_pkg::ENTRY_W-1:0]  head_data,
	output cfcx_pkg::mem_rd_t                  rd,
	output cfcx_pkg::mem_wr_t                  wr,
	output cfcx_pkg::result_t                  res
);

	logic                          use_next_vc_q;
	logic [cfcx_pkg::CRED_W-1:0]   credit_q [cfcx_pkg::NUM_CH];
	logic [cfcx_pkg::PTR_W-1:0]    head_q   [cfcx_pkg::NUM_CH];
	logic [cfcx_pkg::PTR_W-1:0]    tail_q   [cfcx_pkg::NUM_CH];
	logic [cfcx_pkg::FILL_W-1:0]   fill_q   [cfcx_pkg::NUM_CH];

	logic [cfcx_pkg::VC_W-1:0]     vc_in;
	logic [cfcx_pkg::CH_W-1:0]     ch_in;
	logic [cfcx_pkg::PTR_W-1:0]    head_rd;

	logic [cfcx_pkg::VC_W-1:0]     vc_s1;
	logic                          in_range;
	logic [cfcx_pkg::CH_W-1:0]     ch_s1;
	logic [cfcx_pkg::CRED_W-1:0]   cred;
	logic [cfcx_pkg::FILL_W-1:0]   fill;
	logic [cfcx_pkg::PTR_W-1:0]    head;
	logic [cfcx_pkg::PTR_W-1:0]    tail;
	logic [cfcx_pkg::PTR_W-1:0]    head_inc;
	logic [cfcx_pkg::PTR_W-1:0]    tail_inc;
	logic [cfcx_pkg::CRED_W:0]     sum;
	logic [cfcx_pkg::CRED_W-1:0]   sat;
	logic [cfcx_pkg::AMT_W-1:0]    head_bytes;
	logic [cfcx_pkg::TAG_W-1:0]    head_tag;
	logic                          upd_cred;
	logic [cfcx_pkg::CRED_W-1:0]   cred_d;
	logic                          enq;
	logic                          deq;

	// Channel of the incoming item, for the read-ahead of its queue head.
	always_comb begin
		vc_in = (in_item.opcode == cfcx_pkg::OP_PAYLOAD && use_next_vc_q) ?
			in_item.next_vc : in_item.cur_vc;
		ch_in = cfcx_pkg::CH_W'(int'(in_item.port) * cfcx_pkg::NUM_VC + int'(vc_in));
		head_rd = (s1_fire && deq && (ch_s1 == ch_in)) ? head_inc : head_q[ch_in];
		rd.re = in_accept;
		rd.addr = cfcx_pkg::ADDR_W'(int'(ch_in) * cfcx_pkg::QUEUE_DEPTH + int'(head_rd));
	end

	always_comb begin
		vc_s1 = (item_s1.opcode == cfcx_pkg::OP_PAYLOAD && use_next_vc_q) ?
			item_s1.next_vc : item_s1.cur_vc;
		in_range = (int'(item_s1.port) < cfcx_pkg::PORT_COUNT) &&
			(int'(vc_s1) < cfcx_pkg::NUM_VC);
		ch_s1 = cfcx_pkg::CH_W'(int'(item_s1.port) * cfcx_pkg::NUM_VC + int'(vc_s1));
		cred = credit_q[ch_s1];
		fill = fill_q[ch_s1];
		head = head_q[ch_s1];
		tail = tail_q[ch_s1];
		head_inc = (head == cfcx_pkg::PTR_W'(cfcx_pkg::QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
		tail_inc = (tail == cfcx_pkg::PTR_W'(cfcx_pkg::QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
		sum = {1'b0, cred} + (cfcx_pkg::CRED_W + 1)'(item_s1.amount);
		sat = sum[cfcx_pkg::CRED_W] ? cfcx_pkg::CREDIT_MAX : sum[cfcx_pkg::CRED_W-1:0];
		head_bytes = head_data[cfcx_pkg::ENTRY_W-1:cfcx_pkg::TAG_W];
		head_tag = head_data[cfcx_pkg::TAG_W-1:0];

		res = '0;
		res.status = cfcx_pkg::ST_OK;
		upd_cred = 1'b0;
		cred_d = cred;
		enq = 1'b0;
		deq = 1'b0;

		if (!in_range) begin
			if (item_s1.opcode == cfcx_pkg::OP_PAYLOAD) begin
				res.status = cfcx_pkg::ST_DROPPED;
			end
		end else if (item_s1.opcode == cfcx_pkg::OP_PAYLOAD) begin
			if (cred >= cfcx_pkg::CRED_W'(item_s1.amount)) begin
				upd_cred = 1'b1;
				cred_d = cred - cfcx_pkg::CRED_W'(item_s1.amount);
				res.sent = 1'b1;
				res.port = item_s1.port;
				res.vc = vc_s1;
				res.bytes = item_s1.amount;
				res.tag = item_s1.tag;
			end else if (fill >= cfcx_pkg::FILL_W'(cfcx_pkg::QUEUE_DEPTH)) begin
				res.status = cfcx_pkg::ST_DROPPED;
			end else begin
				enq = 1'b1;
				res.status = cfcx_pkg::ST_QUEUED;
			end
		end else begin
			upd_cred = 1'b1;
			cred_d = sat;
			if ((fill != '0) && (cfcx_pkg::CRED_W'(head_bytes) <= sat)) begin
				deq = 1'b1;
				cred_d = sat - cfcx_pkg::CRED_W'(head_bytes);
				res.sent = 1'b1;
				res.port = item_s1.port;
				res.vc = vc_s1;
				res.bytes = head_bytes;
				res.tag = head_tag;
			end
		end

		wr.we = s1_fire && enq;
		wr.addr = cfcx_pkg::ADDR_W'(int'(ch_s1) * cfcx_pkg::QUEUE_DEPTH + int'(tail));
		wr.data = {item_s1.amount, item_s1.tag};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_next_vc_q <= 1'b1;
			for (int i = 0; i < cfcx_pkg::NUM_CH; i++) begin
				credit_q[i] <= cfcx_pkg::per_vc_credits(cfcx_pkg::BASE_CREDITS_RST);
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfcx_pkg::reg_idx_t'(cfg_index))
					cfcx_pkg::REG_BASE_CREDITS: begin
						for (int i = 0; i < cfcx_pkg::NUM_CH; i++) begin
							credit_q[i] <= cfcx_pkg::per_vc_credits(
								cfg_data[cfcx_pkg::CRED_W-1:0]);
						end
					end
					cfcx_pkg::REG_USE_NEXT_VC: begin
						use_next_vc_q <= cfg_data[0];
					end
				endcase
			end
			if (s1_fire) begin
				if (upd_cred) begin
					credit_q[ch_s1] <= cred_d;
				end
				if (enq) begin
					tail_q[ch_s1] <= tail_inc;
					fill_q[ch_s1] <= fill + 1'b1;
				end
				if (deq) begin
					head_q[ch_s1] <= head_inc;
					fill_q[ch_s1] <= fill - 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/credit_flow_control_crossbar_unit.sv
// ----------------------------------------------------------------------------
// credit_flow_control_crossbar_unit
// Credit flow control with one waiting queue per output port and virtual
// channel. Every transfer on the input channel yields exactly one result
// transfer, in order. The block accepts one item per cycle: an accepted item
// waits in the decision stage, where its channel's credit count, queue
// pointers and the queue head read ahead from the wait memory at acceptance
// are combined; its result is registered as the stage fires and offered from
// the next cycle. The rate is bounded by that single decision stage, which
// holds only while the result register is full and not taken. Configuration
// writes take effect at once and no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module credit_flow_control_crossbar_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [cfcx_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [cfcx_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          opcode,
	input  wire logic [cfcx_pkg::PORT_W-1:0]   port,
	input  wire logic [cfcx_pkg::VC_W-1:0]     cur_vc,
	input  wire logic [cfcx_pkg::VC_W-1:0]     next_vc,
	input  wire logic [cfcx_pkg::AMT_W-1:0]    amount,
	input  wire logic [cfcx_pkg::TAG_W-1:0]    tag,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               sent,
	output logic [cfcx_pkg::PORT_W-1:0]        out_port,
	output logic [cfcx_pkg::VC_W-1:0]          out_vc,
	output logic [cfcx_pkg::AMT_W-1:0]         out_bytes,
	output logic [cfcx_pkg::TAG_W-1:0]         out_tag,
	output logic [1:0]                         status
);

	cfcx_pkg::item_t                   in_item;
	cfcx_pkg::item_t                   item_s1;
	logic                              valid_s1;
	logic                              in_accept;
	logic                              s1_fire;
	cfcx_pkg::mem_rd_t                 rd;
	cfcx_pkg::mem_wr_t                 wr;
	logic [cfcx_pkg::ENTRY_W-1:0]      head_data;
	cfcx_pkg::result_t                 res;
	cfcx_pkg::result_t                 res_q;
	logic                              out_valid_q;

	always_comb begin
		in_item.opcode = cfcx_pkg::opcode_t'(opcode);
		in_item.port = port;
		in_item.cur_vc = cur_vc;
		in_item.next_vc = next_vc;
		in_item.amount = amount;
		in_item.tag = tag;
	end

	assign s1_fire = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_fire;
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_item;
		end
		if (s1_fire) begin
			res_q <= res;
		end
	end

	cfcx_chan_ctrl u_chan_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.in_accept (in_accept),
		.item_s1   (item_s1),
		.s1_fire   (s1_fire),
		.head_data (head_data),
		.rd        (rd),
		.wr        (wr),
		.res       (res)
	);

	cfcx_wait_mem u_wait_mem (
		.clk   (clk),
		.rd    (rd),
		.wr    (wr),
		.rdata (head_data)
	);

	assign out_valid = out_valid_q;
	assign sent = res_q.sent;
	assign out_port = res_q.port;
	assign out_vc = res_q.vc;
	assign out_bytes = res_q.bytes;
	assign out_tag = res_q.tag;
	assign status = res_q.status;

	`CFCX_ASSERT_IMP(a_sent_is_ok, out_valid && sent, status == cfcx_pkg::ST_OK, "forwarded payload with non-ok status")
	`CFCX_ASSERT_IMP(a_unsent_is_zero, out_valid && !sent, out_bytes == '0 && out_tag == '0 && out_port == '0 && out_vc == '0, "payload fields set without a forward")
	`CFCX_ASSERT_NXT(a_stage_to_out, s1_fire, out_valid_q, "decision stage fired but no result offered")
	`CFCX_ASSERT_NXT(a_stage_holds, valid_s1 && !s1_fire, valid_s1 && $stable(item_s1), "stalled decision stage lost its item")

endmodule

`default_nettype wire

### sim/credit_flow_control_crossbar_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// credit_flow_control_crossbar_unit_tb
// Self-checking bench for the credit flow control crossbar. Payload and credit
// transfers go in with random gaps while the result side stalls at random. A
// scoreboard keeps its own copy of the credit counts and waiting queues, works
// out the result of every accepted item and checks each result in order.
// ----------------------------------------------------------------------------

module credit_flow_control_crossbar_unit_tb;

	import cfcx_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SHOW_LIMIT  = 200;

	class credit_scoreboard;
		logic [CRED_W-1:0]  credits [NUM_CH];
		logic [ENTRY_W-1:0] parked [MEM_DEPTH];
		int unsigned        head_idx [NUM_CH];
		int unsigned        tail_idx [NUM_CH];
		int unsigned        waiting [NUM_CH];
		logic [CRED_W-1:0]  base_credits;
		bit                 pick_next_vc;
		result_t            forwards_due [$];
		int                 errors;
		int                 results_seen;

		function new();
			base_credits = BASE_CREDITS_RST;
			pick_next_vc = 1'b1;
			errors = 0;
			results_seen = 0;
			foreach (waiting[c]) begin
				head_idx[c] = 0;
				tail_idx[c] = 0;
				waiting[c] = 0;
			end
			reload_credits();
		endfunction

		function void reload_credits();
			foreach (credits[c])
				credits[c] = CRED_W'(base_credits / NUM_VC);
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
			if (idx == REG_BASE_CREDITS) begin
				base_credits = value;
				reload_credits();
			end else begin
				pick_next_vc = value[0];
			end
		endfunction

		function int pending();
			return forwards_due.size();
		endfunction

		function void log_transfer(item_t it);
			result_t          r;
			logic [VC_W-1:0]  vc;
			int               ch;
			logic [CRED_W:0]  sum;
			logic [ENTRY_W-1:0] head;

			r = '0;
			vc = (it.opcode == OP_PAYLOAD && pick_next_vc) ? it.next_vc : it.cur_vc;
			ch = int'(it.port) * NUM_VC + int'(vc);
			if (it.opcode == OP_PAYLOAD) begin
				if (credits[ch] >= it.amount) begin
					credits[ch] = credits[ch] - it.amount;
					r.sent = 1'b1;
					r.port = it.port;
					r.vc = vc;
					r.bytes = it.amount;
					r.tag = it.tag;
				end else if (waiting[ch] >= QUEUE_DEPTH) begin
					r.status = ST_DROPPED;
				end else begin
					parked[ch * QUEUE_DEPTH + tail_idx[ch]] = {it.amount, it.tag};
					tail_idx[ch] = (tail_idx[ch] + 1) % QUEUE_DEPTH;
					waiting[ch]++;
					r.status = ST_QUEUED;
				end
			end else begin
				sum = credits[ch] + it.amount;
				credits[ch] = (sum > CREDIT_MAX) ? CREDIT_MAX : sum[CRED_W-1:0];
				if (waiting[ch] > 0) begin
					head = parked[ch * QUEUE_DEPTH + head_idx[ch]];
					if (head[ENTRY_W-1:TAG_W] <= credits[ch]) begin
						credits[ch] = credits[ch] - head[ENTRY_W-1:TAG_W];
						head_idx[ch] = (head_idx[ch] + 1) % QUEUE_DEPTH;
						waiting[ch]--;
						r.sent = 1'b1;
						r.port = it.port;
						r.vc = vc;
						r.bytes = head[ENTRY_W-1:TAG_W];
						r.tag = head[TAG_W-1:0];
					end
				end
			end
			forwards_due = {forwards_due, r};
		endfunction

		// Printing stops after a while so that a broken design cannot flood the log,
		// but every mismatch is still counted.
		task report(string msg);
			if (errors < SHOW_LIMIT)
				$display("ERROR: %s", msg);
			errors++;
		endtask

		task check_field(string field, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("result %0d field %s: got %h, expected %h",
					results_seen, field, got, want));
		endtask

		task match_result(result_t got);
			result_t want;

			if (forwards_due.size() == 0) begin
				report($sformatf("result transfer with no item waiting, tag %h", got.tag));
			end else begin
				want = forwards_due.pop_front();
				check_field("sent", 32'(got.sent), 32'(want.sent));
				check_field("out_port", 32'(got.port), 32'(want.port));
				check_field("out_vc", 32'(got.vc), 32'(want.vc));
				check_field("out_bytes", 32'(got.bytes), 32'(want.bytes));
				check_field("out_tag", 32'(got.tag), 32'(want.tag));
				check_field("status", 32'(got.status), 32'(want.status));
			end
			results_seen++;
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic                opcode;
	logic [PORT_W-1:0]   port;
	logic [VC_W-1:0]     cur_vc;
	logic [VC_W-1:0]     next_vc;
	logic [AMT_W-1:0]    amount;
	logic [TAG_W-1:0]    tag;
	logic                out_valid;
	logic                out_ready;
	logic                sent;
	logic [PORT_W-1:0]   out_port;
	logic [VC_W-1:0]     out_vc;
	logic [AMT_W-1:0]    out_bytes;
	logic [TAG_W-1:0]    out_tag;
	logic [1:0]          status;

	credit_scoreboard sb;

	credit_flow_control_crossbar_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.port      (port),
		.cur_vc    (cur_vc),
		.next_vc   (next_vc),
		.amount    (amount),
		.tag       (tag),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sent      (sent),
		.out_port  (out_port),
		.out_vc    (out_vc),
		.out_bytes (out_bytes),
		.out_tag   (out_tag),
		.status    (status)
	);

	always #4 clk = ~clk;

	function automatic int pick_gap();
		int r;

		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [AMT_W-1:0] pick_amount();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3, 4: return AMT_W'($urandom_range(1, 600));
			default: return AMT_W'($urandom);
		endcase
	endfunction

	function automatic item_t make_item(opcode_t op, int p, int cv, int nv, int amt, int tg);
		item_t it;

		it.opcode = op;
		it.port = PORT_W'(p);
		it.cur_vc = VC_W'(cv);
		it.next_vc = VC_W'(nv);
		it.amount = AMT_W'(amt);
		it.tag = TAG_W'(tg);
		return it;
	endfunction

	// Narrow traffic hits four channels only, with heavy credit returns, so
	// that credit counts climb into saturation.
	function automatic item_t pick_item(bit narrow, int credit_pct);
		item_t it;

		it.opcode = ($urandom_range(0, 99) < credit_pct) ? OP_CREDIT : OP_PAYLOAD;
		it.port = narrow ? PORT_W'($urandom_range(0, 1)) : PORT_W'($urandom);
		it.cur_vc = narrow ? VC_W'($urandom_range(0, 1)) : VC_W'($urandom);
		it.next_vc = narrow ? VC_W'($urandom_range(0, 1)) : VC_W'($urandom);
		it.amount = pick_amount();
		if (narrow && it.opcode == OP_CREDIT && $urandom_range(0, 1) == 1)
			it.amount = '1;
		it.tag = TAG_W'($urandom);
		return it;
	endfunction

	task automatic push_item(item_t it, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= it.opcode;
		port <= it.port;
		cur_vc <= it.cur_vc;
		next_vc <= it.next_vc;
		amount <= it.amount;
		tag <= it.tag;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.log_transfer(it);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic settle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_directed();
		push_item(make_item(OP_PAYLOAD, 0, 1, 0, 0, 'hFFFF), pick_gap());
		push_item(make_item(OP_PAYLOAD, 7, 0, 3, 'hFFFF, 0), pick_gap());
		push_item(make_item(OP_PAYLOAD, 7, 2, 3, 100, 'h1234), pick_gap());
		push_item(make_item(OP_CREDIT, 7, 3, 0, 0, 'h5555), pick_gap());
		push_item(make_item(OP_CREDIT, 7, 3, 1, 'hFFFF, 'hAAAA), pick_gap());
		push_item(make_item(OP_CREDIT, 7, 3, 2, 0, 0), pick_gap());
		push_item(make_item(OP_PAYLOAD, 1, 0, 2, 256, 'h0F0F), pick_gap());
		// One more than the queue holds, so the last one is dropped.
		for (int i = 0; i <= QUEUE_DEPTH; i++)
			push_item(make_item(OP_PAYLOAD, 1, $urandom_range(0, 3), 2,
				$urandom_range(1, 'hFFFF), $urandom), pick_gap());
		push_item(make_item(OP_CREDIT, 1, 2, 0, 0, 0), pick_gap());
	endtask

	task automatic run_random(int count, bit narrow, int credit_pct);
		bit calm;

		calm = 1'b0;
		for (int i = 0; i < count; i++) begin
			if (i % 25 == 0)
				calm = ($urandom_range(0, 3) == 0);
			push_item(pick_item(narrow, credit_pct), calm ? 0 : pick_gap());
		end
		in_valid <= 1'b0;
	endtask

	initial begin : stimulus
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_BASE_CREDITS;
		cfg_data <= '0;
		in_valid <= 1'b0;
		opcode <= OP_PAYLOAD;
		port <= '0;
		cur_vc <= '0;
		next_vc <= '0;
		amount <= '0;
		tag <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random(150, 1'b0, 50);
		settle();

		cfg_write(REG_BASE_CREDITS, '0);
		cfg_write(REG_USE_NEXT_VC, '0);
		cfg_we <= 1'b0;
		run_random(150, 1'b0, 50);
		settle();

		cfg_write(REG_BASE_CREDITS, CREDIT_MAX);
		cfg_write(REG_USE_NEXT_VC, CFG_W'(1));
		cfg_we <= 1'b0;
		run_random(150, 1'b1, 75);
		settle();

		cfg_write(REG_BASE_CREDITS, CFG_W'($urandom_range(1, 4096)));
		cfg_write(REG_USE_NEXT_VC, '0);
		cfg_we <= 1'b0;
		run_random(150, 1'b0, 50);
		settle();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// The result side also makes one long hold early on, so the block fills up
	// and stops taking input while the sender keeps offering items.
	initial begin : result_side
		result_t got;
		int      stall_left;
		int      cyc;
		bit      calm;

		stall_left = 0;
		cyc = 0;
		calm = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0)
				calm = ($urandom_range(0, 2) == 0);
			if (out_valid && out_ready) begin
				got.sent = sent;
				got.port = out_port;
				got.vc = out_vc;
				got.bytes = out_bytes;
				got.tag = out_tag;
				got.status = status_t'(status);
				sb.match_result(got);
				if (sb.results_seen == 60)
					stall_left = 400;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
				out_ready <= (stall_left == 0);
			end
		end
	end

	initial begin : watchdog
		int quiet;

		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
